[hdl/hse_pkg.sv]
package hse_pkg;

  localparam int DEPTH  = 64;
  localparam int DATA_W = 32;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     last;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] sorted_value;
    logic                     end_of_batch;
    logic                     dropped;
  } out_item_t;

  // broadcast control to every cell
  typedef struct packed {
    logic load;   // insert the broadcast value in sorted position
    logic shift;  // move every value one cell toward the head
  } cell_ctl_t;

  // what one cell shows its neighbors
  typedef struct packed {
    logic                     lt;   // broadcast value goes at or before this cell
    logic                     occ;  // cell holds a value of this batch
    logic signed [DATA_W-1:0] val;
  } cell_link_t;

endpackage

[hdl/heap_sort_engine_unit.sv]
// Batch sorter for signed 32-bit values, built as a row of DEPTH compare cells
// kept in ascending order. Each request is inserted straight into its sorted
// position; a request arriving with all cells full is dropped and flagged on
// every result of the batch. After the request marked last, in_stall rises and
// the results leave from the head cell, smallest first, one per cycle while
// out_stall is low, starting the cycle after the last request. Loading and
// draining both rest on the single broadcast-and-shift step of the cell row.
// Input is taken again once the result flagged end_of_batch is taken.
module heap_sort_engine_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  hse_pkg::in_item_t   in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output hse_pkg::out_item_t  out_item
);
  import hse_pkg::*;

  typedef enum logic {
    ST_LOAD,
    ST_DRAIN
  } state_t;

  state_t     state_r;
  logic       overflow_r;
  cell_ctl_t  ctl;
  cell_link_t head;
  logic       second_occ;
  logic       full;
  logic       in_accept;
  logic       out_take;

  assign in_stall  = (state_r == ST_DRAIN);
  assign in_accept = in_valid && !in_stall;
  assign out_valid = (state_r == ST_DRAIN) && head.occ;
  assign out_take  = out_valid && !out_stall;

  assign ctl.load  = in_accept && !full;
  assign ctl.shift = out_take;

  hse_chain u_chain (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .ins_val    (in_item.value),
    .head       (head),
    .second_occ (second_occ),
    .full       (full)
  );

  assign out_item.sorted_value = head.val;
  assign out_item.end_of_batch = !second_occ;
  assign out_item.dropped      = overflow_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_LOAD;
      overflow_r <= 1'b0;
    end else begin
      unique case (state_r)
        ST_LOAD: begin
          if (in_accept) begin
            if (full) begin
              overflow_r <= 1'b1;
            end
            if (in_item.last) begin
              state_r <= ST_DRAIN;
            end
          end
        end
        ST_DRAIN: begin
          if (out_take && out_item.end_of_batch) begin
            state_r    <= ST_LOAD;
            overflow_r <= 1'b0;
          end
        end
        default: state_r <= ST_LOAD;
      endcase
    end
  end

  // draining never runs with an empty head cell
  a_drain_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DRAIN) |-> head.occ)
    else $error("drain state with empty head cell");

  a_end_closes: assert property (@(posedge clk) disable iff (!rst_n)
    out_take && out_item.end_of_batch |=> !out_valid && !in_stall)
    else $error("results continue after end of batch");

  a_last_drains: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && in_item.last |=> out_valid)
    else $error("no result after last request");

  a_no_load_shift: assert property (@(posedge clk) disable iff (!rst_n)
    !(ctl.load && ctl.shift))
    else $error("insert and shift in the same cycle");

  a_drop_kept: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && full |=> overflow_r)
    else $error("dropped request not flagged");

endmodule

[hdl/hse_cell.sv]
module hse_cell (
  input  logic                              clk,
  input  logic                              rst_n,
  input  hse_pkg::cell_ctl_t                ctl,
  input  logic signed [hse_pkg::DATA_W-1:0] ins_val,
  input  hse_pkg::cell_link_t               left_link,
  input  hse_pkg::cell_link_t               right_link,
  output hse_pkg::cell_link_t               link
);
  import hse_pkg::*;

  logic                     occ_r, occ_nxt;
  logic signed [DATA_W-1:0] val_r, val_nxt;
  logic                     lt;

  // an empty cell counts as +infinity, so the row stays ascending
  assign lt = !occ_r || (ins_val < val_r);

  always_comb begin
    occ_nxt = occ_r;
    val_nxt = val_r;
    if (ctl.load) begin
      occ_nxt = left_link.occ;
      if (left_link.lt) begin
        val_nxt = left_link.val;
      end else if (lt) begin
        val_nxt = ins_val;
      end
    end else if (ctl.shift) begin
      occ_nxt = right_link.occ;
      val_nxt = right_link.val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 1'b0;
    end else begin
      occ_r <= occ_nxt;
    end
    val_r <= val_nxt;
  end

  assign link.lt  = lt;
  assign link.occ = occ_r;
  assign link.val = val_r;

endmodule

[hdl/hse_chain.sv]
module hse_chain (
  input  logic                              clk,
  input  logic                              rst_n,
  input  hse_pkg::cell_ctl_t                ctl,
  input  logic signed [hse_pkg::DATA_W-1:0] ins_val,
  output hse_pkg::cell_link_t               head,
  output logic                              second_occ,
  output logic                              full
);
  import hse_pkg::*;

  cell_link_t links [DEPTH];
  cell_link_t left_in [DEPTH];
  cell_link_t right_in [DEPTH];

  // head side: nothing smaller in front, always "occupied" so an insert fills cell 0
  localparam cell_link_t HEAD_EDGE = '{lt: 1'b0, occ: 1'b1, val: '0};
  localparam cell_link_t TAIL_EDGE = '{lt: 1'b1, occ: 1'b0, val: '0};

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign left_in[i] = HEAD_EDGE;
    end else begin : g_mid_l
      assign left_in[i] = links[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_in[i] = TAIL_EDGE;
    end else begin : g_mid_r
      assign right_in[i] = links[i+1];
    end

    hse_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .ins_val    (ins_val),
      .left_link  (left_in[i]),
      .right_link (right_in[i]),
      .link       (links[i])
    );
  end

  assign head       = links[0];
  assign second_occ = links[1].occ;
  assign full       = links[DEPTH-1].occ;

endmodule
